// ----- rtl/core/command_frame_receive_parser_core_assert.svh -----
// Assertion macros for the command frame receive parser core
`ifndef COMMAND_FRAME_RECEIVE_PARSER_CORE_ASSERT_SVH
`define COMMAND_FRAME_RECEIVE_PARSER_CORE_ASSERT_SVH

`ifndef SYNTH
`define CFPC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("command frame parser assertion failed");
`define CFPC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("command frame parser assertion failed");
`else
`define CFPC_ASSERT(lbl, prop)
`define CFPC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- rtl/core/cfpc_pkg.sv -----
// Shared types, codes and helper function of the command frame parser
package cfpc_pkg;

	localparam logic [7:0] HDR_FIRST_RST  = 8'h4D;
	localparam logic [7:0] HDR_SECOND_RST = 8'h41;

	localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
	localparam logic [1:0] REG_HEADER_SECOND = 2'd1;

	localparam logic [7:0] LETTER_D = 8'h44;
	localparam logic [7:0] LETTER_W = 8'h57;
	localparam logic [7:0] LETTER_P = 8'h50;
	localparam logic [7:0] LETTER_C = 8'h43;
	localparam logic [7:0] LETTER_B = 8'h42;
	localparam logic [7:0] LETTER_T = 8'h54;
	localparam logic [7:0] LETTER_R = 8'h52;
	localparam logic [7:0] LETTER_S = 8'h53;

	localparam logic [7:0] SUB_CLOUD_OK   = 8'h01;
	localparam logic [7:0] SUB_CLOUD_FAIL = 8'h00;
	localparam logic [7:0] SUB_FAST_BLINK = 8'h52;
	localparam logic [7:0] SUB_POWER_ON   = 8'h54;
	localparam logic [7:0] SUB_POWER_OFF  = 8'h53;

	localparam logic [3:0] KIND_PANEL      = 4'd0;
	localparam logic [3:0] KIND_CLOUD_OK   = 4'd1;
	localparam logic [3:0] KIND_CLOUD_FAIL = 4'd2;
	localparam logic [3:0] KIND_FAST_BLINK = 4'd3;
	localparam logic [3:0] KIND_POWER_ON   = 4'd4;
	localparam logic [3:0] KIND_POWER_OFF  = 4'd5;
	localparam logic [3:0] KIND_SET_TEMP   = 4'd6;
	localparam logic [3:0] KIND_COMMAND    = 4'd7;
	localparam logic [3:0] KIND_CLOCK_TIME = 4'd8;
	localparam logic [3:0] KIND_SET_TIMING = 4'd9;
	localparam logic [3:0] KIND_REFERENCE  = 4'd10;
	localparam logic [3:0] KIND_FAN        = 4'd11;

	localparam logic [1:0] ACT_LEAVE = 2'd0;
	localparam logic [1:0] ACT_SET   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	typedef struct packed {
		logic       hit;
		logic [3:0] kind;
		logic [7:0] p1;
		logic [7:0] p2;
		logic [7:0] p3;
		logic [4:0] tens;
		logic [3:0] units;
		logic [1:0] action;
	} result_t;

	function automatic result_t make_result(input logic [3:0] kind, input logic [7:0] p1,
			input logic [7:0] p2, input logic [7:0] p3, input logic [1:0] action);
		result_t    r;
		logic [15:0] prod;
		logic [7:0]  rem;
		prod     = {8'd0, p1} * 16'd205;
		r.hit    = 1'b1;
		r.kind   = kind;
		r.p1     = p1;
		r.p2     = p2;
		r.p3     = p3;
		r.tens   = prod[15:11];
		rem      = p1 - ({3'd0, prod[15:11]} * 8'd10);
		r.units  = rem[3:0];
		r.action = action;
		return r;
	endfunction

endpackage

// ----- rtl/core/cfpc_parse.sv -----
// Frame phase tracking and result decode for one received byte
module cfpc_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       rx_byte_s1,
	input  logic [7:0]       header_first,
	input  logic [7:0]       header_second,
	output cfpc_pkg::result_t res
);
	import cfpc_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_HDR1 = 3'd1;
	localparam logic [2:0] PH_HDR2 = 3'd2;
	localparam logic [2:0] PH_PAY1 = 3'd3;
	localparam logic [2:0] PH_PAY2 = 3'd4;
	localparam logic [2:0] PH_PAY3 = 3'd5;

	localparam logic [2:0] TY_D = 3'd0;
	localparam logic [2:0] TY_W = 3'd1;
	localparam logic [2:0] TY_P = 3'd2;
	localparam logic [2:0] TY_C = 3'd3;
	localparam logic [2:0] TY_B = 3'd4;
	localparam logic [2:0] TY_T = 3'd5;
	localparam logic [2:0] TY_R = 3'd6;
	localparam logic [2:0] TY_S = 3'd7;

	logic [2:0] phase_q, phase_d;
	logic [2:0] type_q, type_d;
	logic [7:0] held_first_q, held_first_d;
	logic [7:0] held_second_q, held_second_d;

	always_comb begin
		phase_d       = phase_q;
		type_d        = type_q;
		held_first_d  = held_first_q;
		held_second_d = held_second_q;
		res           = '0;
		case (phase_q)
			PH_IDLE: begin
				if (rx_byte_s1 == header_first) begin
					phase_d = PH_HDR1;
				end
			end
			PH_HDR1: begin
				phase_d = (rx_byte_s1 == header_second) ? PH_HDR2 : PH_IDLE;
			end
			PH_HDR2: begin
				phase_d = PH_PAY1;
				case (rx_byte_s1)
					LETTER_D: type_d = TY_D;
					LETTER_W: type_d = TY_W;
					LETTER_P: type_d = TY_P;
					LETTER_C: type_d = TY_C;
					LETTER_B: type_d = TY_B;
					LETTER_T: type_d = TY_T;
					LETTER_R: type_d = TY_R;
					LETTER_S: type_d = TY_S;
					default:  phase_d = PH_IDLE;
				endcase
			end
			PH_PAY1: begin
				phase_d = PH_IDLE;
				case (type_q)
					TY_D, TY_B, TY_R: begin
						held_first_d = rx_byte_s1;
						phase_d      = PH_PAY2;
					end
					TY_W: begin
						case (rx_byte_s1)
							SUB_CLOUD_OK:   res = make_result(KIND_CLOUD_OK, rx_byte_s1,
								8'd0, 8'd0, ACT_LEAVE);
							SUB_CLOUD_FAIL: res = make_result(KIND_CLOUD_FAIL, rx_byte_s1,
								8'd0, 8'd0, ACT_LEAVE);
							SUB_FAST_BLINK: res = make_result(KIND_FAST_BLINK, rx_byte_s1,
								8'd0, 8'd0, ACT_CLEAR);
							SUB_POWER_ON:   res = make_result(KIND_POWER_ON, rx_byte_s1,
								8'd0, 8'd0, ACT_SET);
							SUB_POWER_OFF:  res = make_result(KIND_POWER_OFF, rx_byte_s1,
								8'd0, 8'd0, ACT_SET);
							default:        phase_d = PH_PAY1;
						endcase
					end
					TY_P:    res = make_result(KIND_SET_TEMP, rx_byte_s1, 8'd0, 8'd0, ACT_SET);
					TY_C:    res = make_result(KIND_COMMAND, rx_byte_s1, 8'd0, 8'd0, ACT_SET);
					TY_T:    res = make_result(KIND_SET_TIMING, rx_byte_s1, 8'd0, 8'd0,
						ACT_SET);
					default: res = make_result(KIND_FAN, rx_byte_s1, 8'd0, 8'd0, ACT_SET);
				endcase
			end
			PH_PAY2: begin
				phase_d = PH_IDLE;
				case (type_q)
					TY_D:       res = make_result(KIND_PANEL, held_first_q, rx_byte_s1, 8'd0,
						ACT_SET);
					TY_B, TY_R: begin
						held_second_d = rx_byte_s1;
						phase_d       = PH_PAY3;
					end
					default: ;
				endcase
			end
			PH_PAY3: begin
				phase_d = PH_IDLE;
				case (type_q)
					TY_B:    res = make_result(KIND_CLOCK_TIME, held_first_q, held_second_q,
						rx_byte_s1, ACT_SET);
					TY_R:    res = make_result(KIND_REFERENCE, held_first_q, held_second_q,
						rx_byte_s1, ACT_SET);
					default: ;
				endcase
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			type_q        <= TY_D;
			held_first_q  <= 8'd0;
			held_second_q <= 8'd0;
		end else if (advance) begin
			phase_q       <= phase_d;
			type_q        <= type_d;
			held_first_q  <= held_first_d;
			held_second_q <= held_second_d;
		end
	end

endmodule

// ----- rtl/core/cfpc_out_reg.sv -----
// Result register holding one decoded frame until the receiver takes it
module cfpc_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  cfpc_pkg::result_t res,
	input  logic              res_ready,
	output logic              res_valid,
	output logic [3:0]        frame_kind,
	output logic [7:0]        payload_first,
	output logic [7:0]        payload_second,
	output logic [7:0]        payload_third,
	output logic [4:0]        temp_tens,
	output logic [3:0]        temp_units,
	output logic [1:0]        decode_action
);
	import cfpc_pkg::*;

	logic valid_q;
	result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign res_valid      = valid_q;
	assign frame_kind     = data_q.kind;
	assign payload_first  = data_q.p1;
	assign payload_second = data_q.p2;
	assign payload_third  = data_q.p3;
	assign temp_tens      = data_q.tens;
	assign temp_units     = data_q.units;
	assign decode_action  = data_q.action;

endmodule

// ----- rtl/core/command_frame_receive_parser_core.sv -----
// Top level of the command frame receive parser
//
// Bytes enter on rx_valid/rx_ready/rx_byte, one request per byte. A byte is
// registered in the input register, then decoded against the frame phase, and a
// completed frame lands in the result register: res_valid rises once the last
// byte of a frame has been decoded into it. Every other byte gives no result.
// Throughput is one byte per cycle, set by the single decode stage, while no held result waits on res_ready.
// Header bytes are written on cfg_valid/cfg_index/cfg_data; index 0 is the
// first header byte, index 1 the second, other indexes are dropped. cfg_ready
// is always high. Write the headers only while no frame is in flight.
// Reset clears the phase to idle, empties both stages and loads the headers
// with 'M' and 'A'. When res_ready is low with a result held, the decode stage
// holds and rx_ready drops once the input register is full; no byte is lost.
module command_frame_receive_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [3:0] frame_kind,
	output logic [7:0] payload_first,
	output logic [7:0] payload_second,
	output logic [7:0] payload_third,
	output logic [4:0] temp_tens,
	output logic [3:0] temp_units,
	output logic [1:0] decode_action,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import cfpc_pkg::*;

	`include "command_frame_receive_parser_core_assert.svh"

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic [7:0] header_first_q;
	logic [7:0] header_second_q;
	logic       advance;
	result_t    res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= HDR_FIRST_RST;
			header_second_q <= HDR_SECOND_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HEADER_FIRST:  header_first_q  <= cfg_data;
				REG_HEADER_SECOND: header_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!res_valid || res_ready);
	assign rx_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	cfpc_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.rx_byte_s1    (rx_byte_s1),
		.header_first  (header_first_q),
		.header_second (header_second_q),
		.res           (res)
	);

	cfpc_out_reg u_out_reg (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (advance && res.hit),
		.res            (res),
		.res_ready      (res_ready),
		.res_valid      (res_valid),
		.frame_kind     (frame_kind),
		.payload_first  (payload_first),
		.payload_second (payload_second),
		.payload_third  (payload_third),
		.temp_tens      (temp_tens),
		.temp_units     (temp_units),
		.decode_action  (decode_action)
	);

	`CFPC_ASSERT(a_digits_match, res_valid |-> (({4'd0, temp_tens} * 9'd10 + {5'd0, temp_units}) == {1'b0, payload_first}))
	`CFPC_ASSERT(a_panel_sets_flag, (res_valid && frame_kind == KIND_PANEL) |-> (decode_action == ACT_SET))
	`CFPC_ASSERT(a_short_frame_zero, (res_valid && frame_kind != KIND_PANEL && frame_kind != KIND_CLOCK_TIME && frame_kind != KIND_REFERENCE) |-> (payload_second == 8'd0 && payload_third == 8'd0))
	`CFPC_ASSERT(a_stall_cause, !rx_ready |-> (valid_s1 && res_valid && !res_ready))
	`CFPC_ASSERT_ALWAYS(a_reset_empty, $rose(arst_n) |-> (!res_valid && !valid_s1))

endmodule
